/* sv/uer_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the ultrasonic echo ranger.
// Depends on nothing; imported by every module of the block.
package uer_pkg;

  // Counter sizing: one bit above the count so the overrun tick is seen
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;

  // Configuration port sizing and register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_POLARITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH     = 2'd3;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
  localparam logic        POLARITY_RST  = 1'b1;
  localparam logic [7:0]  TRIG_LOW_RST  = 8'd2;
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;

  // Distance scaling: (width * DIST_MUL) >> 16, saturated at DIST_MAX
  localparam int DIST_W    = 17;
  localparam int PROD_W    = 16 + DIST_W;
  localparam logic [PROD_W-1:0] DIST_MUL = 33'd112604;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'd112600;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OLD_PULSE  = 2'd1;
  localparam logic [1:0] ST_NO_START   = 2'd2;
  localparam logic [1:0] ST_WIDTH_OVER = 2'd3;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic        echo_polarity;
    logic [7:0]  trig_low;
    logic [7:0]  trig_high;
  } cfg_t;

  typedef struct packed {
    logic        trigger;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [15:0] width;
  } seq_res_t;

endpackage

/* sv/uer_cfg.sv */
`timescale 1ns / 1ps
// Configuration register bank of the ultrasonic echo ranger.
// Depends on uer_pkg for the register indexes, reset values and cfg_t.
module uer_cfg
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Write the addressed register; reset restores defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit <= TIMEOUT_RST;
      cfg_r.echo_polarity <= POLARITY_RST;
      cfg_r.trig_low      <= TRIG_LOW_RST;
      cfg_r.trig_high     <= TRIG_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT_LIMIT: cfg_r.timeout_limit <= cfg_wdata;
        REG_ECHO_POLARITY: cfg_r.echo_polarity <= cfg_wdata[0];
        REG_TRIG_LOW:      cfg_r.trig_low      <= cfg_wdata[7:0];
        REG_TRIG_HIGH:     cfg_r.trig_high     <= cfg_wdata[7:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/uer_seq.sv */
`timescale 1ns / 1ps
// Measurement sequencer: phase and phase counter, one tick per step.
// Depends on uer_pkg for cfg_t, seq_res_t, counter width and status codes.
module uer_seq
  import uer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  logic     start,
  input  logic     echo,
  input  cfg_t     cfg,
  output seq_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TLOW   = 3'd1,
    PH_THIGH  = 3'd2,
    PH_WEND   = 3'd3,
    PH_WSTART = 3'd4,
    PH_MEAS   = 3'd5
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim;
  logic             active;
  logic             go;

  // Cap the timeout at the counter range
  generate
    if (COUNT_BITS >= 16) begin : g_nocap
      assign lim = CNT_W'(cfg.timeout_limit);
    end else begin : g_cap
      assign lim = (|cfg.timeout_limit[15:COUNT_BITS]) ?
                   {1'b0, {COUNT_BITS{1'b1}}} :
                   {1'b0, cfg.timeout_limit[COUNT_BITS-1:0]};
    end
  endgenerate

  assign active = (echo == cfg.echo_polarity);

  // Walk the phases for this tick; a phase that completes falls through
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    go        = 1'b1;
    res       = '0;

    if (phase_nxt == PH_IDLE) begin
      if (!start) begin
        go = 1'b0;
      end else begin
        phase_nxt = PH_TLOW;
        cnt_nxt   = '0;
      end
    end
    if (go) res.busy = 1'b1;

    if (go && phase_nxt == PH_TLOW) begin
      if (cnt_nxt < CNT_W'(cfg.trig_low)) begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
        go      = 1'b0;
      end else begin
        phase_nxt = PH_THIGH;
        cnt_nxt   = '0;
      end
    end

    if (go && phase_nxt == PH_THIGH) begin
      if (cnt_nxt < CNT_W'(cfg.trig_high)) begin
        cnt_nxt     = cnt_nxt + CNT_W'(1);
        res.trigger = 1'b1;
        go          = 1'b0;
      end else begin
        phase_nxt = PH_WEND;
        cnt_nxt   = '0;
      end
    end

    // Wait for an earlier pulse to end
    if (go && phase_nxt == PH_WEND) begin
      if (active) begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
        go      = 1'b0;
        if (cnt_nxt > lim) begin
          res.done   = 1'b1;
          res.status = ST_OLD_PULSE;
        end
      end else begin
        phase_nxt = PH_WSTART;
        cnt_nxt   = '0;
      end
    end

    // Wait for the pulse to begin; its first active tick counts
    if (go && phase_nxt == PH_WSTART) begin
      go = 1'b0;
      if (!active) begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (cnt_nxt > lim) begin
          res.done   = 1'b1;
          res.status = ST_NO_START;
        end
      end else begin
        phase_nxt = PH_MEAS;
        cnt_nxt   = CNT_W'(1);
        if (cnt_nxt > lim) begin
          res.done   = 1'b1;
          res.status = ST_WIDTH_OVER;
        end
      end
    end

    // Count active ticks until the pulse drops
    if (go && phase_nxt == PH_MEAS) begin
      go = 1'b0;
      if (!active) begin
        res.done   = 1'b1;
        res.status = ST_OK;
        res.width  = 16'(cnt_nxt);
      end else begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (cnt_nxt > lim) begin
          res.done   = 1'b1;
          res.status = ST_WIDTH_OVER;
        end
      end
    end

    // Drop back to idle on an unused phase code
    if (go && res.busy) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      res.busy  = 1'b0;
    end

    // Finish: idle on the next tick
    if (res.done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      res.busy  = 1'b0;
    end
  end

  // Advance state once per stepped tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done |=> phase_r == PH_IDLE && cnt_r == '0)
    else $error("sequencer not idle after finish");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cnt_r == '0)
    else $error("counter nonzero in idle");
  a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.trigger |=> phase_r == PH_THIGH)
    else $error("trigger driven outside trigger-high phase");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(cnt_r))
    else $error("state moved without a step");
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    !res.done |-> res.status == ST_OK && res.width == '0)
    else $error("result fields set without finish");
`endif

endmodule

/* sv/ultrasonic_echo_ranger_core.sv */
`timescale 1ns / 1ps
// Ultrasonic echo ranger: one request per microsecond tick, one result each.
// Each accepted request waits in the input register until its result is registered.
// Throughput: one request per cycle while out_ready holds; each register holds one.
// Reset (rst_n low, synchronous): sequencer idle, counter zero, both stages
// empty, configuration back to its defaults.
// Depends on uer_pkg, uer_cfg and uer_seq.
module ultrasonic_echo_ranger_core
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_start_request,
  input  logic                  in_echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger_level,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [1:0]            out_status,
  output logic [15:0]           out_pulse_width,
  output logic [DIST_W-1:0]     out_distance_centi,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg;
  seq_res_t          res;
  logic              s1_valid_r;
  logic              s1_start_r;
  logic              s1_echo_r;
  logic              adv;
  logic              out_valid_r;
  seq_res_t          out_res_r;
  logic [DIST_W-1:0] dist_r;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] dist_nxt;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .start (s1_start_r),
    .echo  (s1_echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Move the held request on when the result register is free
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start_r <= in_start_request;
      s1_echo_r  <= in_echo_level;
    end
  end

  // Scale width to distance and saturate
  assign prod     = PROD_W'(res.width) * DIST_MUL;
  assign dist_nxt = (prod[PROD_W-1:16] > DIST_MAX) ? DIST_MAX : prod[PROD_W-1:16];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
      dist_r    <= dist_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_level  = out_res_r.trigger;
  assign out_busy_res       = out_res_r.busy;
  assign out_done_res       = out_res_r.done;
  assign out_status         = out_res_r.status;
  assign out_pulse_width    = out_res_r.width;
  assign out_distance_centi = dist_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for ultrasonic_echo_ranger_core: drives tick requests and
// checks every result against a cycle-exact predictor of the ranging sequence.
// Depends on uer_pkg and the ultrasonic_echo_ranger_core RTL.
module tb_top;
  import uer_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    RANGE_IDLE,
    RANGE_TRIG_LOW,
    RANGE_TRIG_HIGH,
    RANGE_OLD_END,
    RANGE_WAIT_RISE,
    RANGE_MEASURE
  } range_phase_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [15:0]       width;
    logic [DIST_W-1:0] distance;
  } echo_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_start_request;
  logic in_echo_level;
  logic out_valid;
  logic out_ready;
  logic out_trigger_level;
  logic out_busy_res;
  logic out_done_res;
  logic [1:0] out_status;
  logic [15:0] out_pulse_width;
  logic [DIST_W-1:0] out_distance_centi;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state and its copy of the register file
  range_phase_t rng_phase;
  logic [CNT_W-1:0] rng_count;
  logic [15:0] cfg_limit;
  logic cfg_pol;
  logic [7:0] cfg_lo;
  logic [7:0] cfg_hi;

  echo_result_t pending_results[$];
  int unsigned ticks_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  ultrasonic_echo_ranger_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_request  (in_start_request),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .out_pulse_width   (out_pulse_width),
    .out_distance_centi(out_distance_centi),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Timeout limit as the counter sees it: capped at the counter range
  function automatic logic [CNT_W-1:0] eff_limit();
    logic [63:0] cap;
    logic [63:0] lim;
    cap = (64'd1 << COUNT_BITS) - 64'd1;
    lim = 64'(cfg_limit);
    return CNT_W'((lim < cap) ? lim : cap);
  endfunction

  // Close a measurement: scale width to distance, zero both on a timeout
  function automatic echo_result_t finish_result(logic [1:0] code, logic [15:0] width);
    echo_result_t r;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] distance;
    r = '0;
    prod = width * DIST_MUL;
    distance = prod[16 +: DIST_W];
    if (distance > DIST_MAX) distance = DIST_MAX;
    if (code != ST_OK) begin
      width = '0;
      distance = '0;
    end
    r.done = 1'b1;
    r.status = code;
    r.width = width;
    r.distance = distance;
    rng_phase = RANGE_IDLE;
    rng_count = '0;
    return r;
  endfunction

  // Advance the ranging sequence by one tick; phases fall through on the same tick
  function automatic echo_result_t advance_ranger(bit start, bit echo);
    echo_result_t r;
    bit active;
    logic [CNT_W-1:0] lim;
    r = '0;
    active = (echo == cfg_pol);
    lim = eff_limit();
    if (rng_phase == RANGE_IDLE) begin
      if (!start) return r;
      rng_phase = RANGE_TRIG_LOW;
      rng_count = '0;
    end
    r.busy = 1'b1;
    if (rng_phase == RANGE_TRIG_LOW) begin
      if (rng_count < cfg_lo) begin
        rng_count++;
        return r;
      end
      rng_phase = RANGE_TRIG_HIGH;
      rng_count = '0;
    end
    if (rng_phase == RANGE_TRIG_HIGH) begin
      if (rng_count < cfg_hi) begin
        rng_count++;
        r.trigger = 1'b1;
        return r;
      end
      rng_phase = RANGE_OLD_END;
      rng_count = '0;
    end
    if (rng_phase == RANGE_OLD_END) begin
      if (active) begin
        rng_count++;
        if (rng_count > lim) return finish_result(ST_OLD_PULSE, '0);
        return r;
      end
      rng_phase = RANGE_WAIT_RISE;
      rng_count = '0;
    end
    if (rng_phase == RANGE_WAIT_RISE) begin
      if (!active) begin
        rng_count++;
        if (rng_count > lim) return finish_result(ST_NO_START, '0);
        return r;
      end
      rng_phase = RANGE_MEASURE;
      rng_count = CNT_W'(1);
      if (rng_count > lim) return finish_result(ST_WIDTH_OVER, '0);
      return r;
    end
    if (!active) return finish_result(ST_OK, 16'(rng_count));
    rng_count++;
    if (rng_count > lim) return finish_result(ST_WIDTH_OVER, '0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Send one tick request, idling first at random; called and returns at a falling edge
  task automatic send_tick(input bit start, input bit echo);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_start_request <= 1'($urandom_range(1));
      in_echo_level <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_request <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(advance_ranger(start, echo));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Hold off requests until every result is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Reprogram all four registers while the block is idle; unused upper bits get junk
  task automatic program_ranger(input logic [15:0] limit, input bit pol,
                                input logic [7:0] lo, input logic [7:0] hi);
    wait_drained();
    write_reg(REG_TIMEOUT_LIMIT, limit);
    write_reg(REG_ECHO_POLARITY, {15'($urandom), pol});
    write_reg(REG_TRIG_LOW, {8'($urandom), lo});
    write_reg(REG_TRIG_HIGH, {8'($urandom), hi});
    cfg_we <= 1'b0;
    cfg_limit = limit;
    cfg_pol = pol;
    cfg_lo = lo;
    cfg_hi = hi;
  endtask

  // One full measurement: an old pulse, a gap, then the echo pulse, counted
  // from the first tick after the trigger; runs until the block is idle again
  task automatic run_measurement(input int unsigned old_len, input int unsigned gap_len,
                                 input int unsigned width_len, input bit noisy);
    int unsigned k;
    int unsigned t0;
    int unsigned rel;
    bit act;
    t0 = cfg_lo + cfg_hi;
    k = 0;
    do begin
      if (k < t0) begin
        act = 1'($urandom_range(1));
      end else begin
        rel = k - t0;
        act = (rel < old_len) ||
              (rel >= old_len + gap_len && rel < old_len + gap_len + width_len);
      end
      if (noisy && $urandom_range(9) == 0) act = !act;
      send_tick(k == 0 ? 1'b1 : 1'($urandom_range(1)), act ? cfg_pol : !cfg_pol);
      k++;
    end while (rng_phase != RANGE_IDLE);
  endtask

  task automatic test_default_setup();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    run_measurement(3, 4, 25, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_active_low_echo();
    program_ranger(16'd40, 1'b0, 8'd1, 8'd3);
    run_measurement(2, 3, 17, 1'b0);
    run_measurement(0, 0, 1, 1'b0);
  endtask

  task automatic test_trigger_extremes();
    program_ranger(16'd20, 1'b1, 8'd0, 8'd0);
    run_measurement(0, 0, 5, 1'b0);
    run_measurement(2, 1, 3, 1'b0);
    program_ranger(16'd20, 1'b0, 8'd0, 8'd64);
    run_measurement(1, 1, 3, 1'b0);
    program_ranger(16'd20, 1'b1, 8'd0, 8'd1);
    run_measurement(0, 2, 2, 1'b0);
    program_ranger(16'd20, 1'b1, 8'd3, 8'd0);
    run_measurement(1, 0, 6, 1'b0);
  endtask

  task automatic test_phase_timeouts();
    program_ranger(16'd4, 1'b1, 8'd1, 8'd1);
    run_measurement(9, 0, 0, 1'b0);
    run_measurement(0, 9, 3, 1'b0);
    run_measurement(0, 0, 9, 1'b0);
    run_measurement(4, 4, 4, 1'b0);
    // zero limit: every wait expires on its first counted tick
    program_ranger(16'd0, 1'b1, 8'd1, 8'd1);
    run_measurement(1, 0, 3, 1'b0);
    run_measurement(0, 1, 3, 1'b0);
    run_measurement(0, 0, 3, 1'b0);
    program_ranger(16'd1, 1'b0, 8'd0, 8'd2);
    run_measurement(1, 1, 1, 1'b0);
  endtask

  // Full-scale timeout limit: a long pulse completes without a timeout
  task automatic test_long_pulse();
    program_ranger(16'hFFFF, 1'b1, 8'd2, 8'd10);
    run_measurement(0, 3, 40, 1'b0);
  endtask

  task automatic random_setup();
    logic [15:0] limit;
    logic [7:0] lo;
    logic [7:0] hi;
    limit = ($urandom_range(3) == 0) ? 16'($urandom_range(2)) : 16'($urandom_range(3, 16));
    lo = ($urandom_range(15) == 0) ? 8'($urandom_range(4, 12)) : 8'($urandom_range(3));
    hi = ($urandom_range(15) == 0) ? 8'($urandom_range(4, 12)) : 8'($urandom_range(3));
    program_ranger(limit, 1'($urandom_range(1)), lo, hi);
  endtask

  // Mostly well-formed measurements with random lengths; some glitchy echoes,
  // stray ticks and full drains in between
  task automatic test_random_traffic(input int sp, input int rp, input int unsigned n);
    int unsigned stop_at;
    int unsigned span;
    int unsigned old_len;
    send_idle_pct = sp;
    recv_stall_pct = rp;
    stop_at = ticks_sent + n;
    random_setup();
    while (ticks_sent < stop_at) begin
      if ($urandom_range(7) == 0) random_setup();
      span = cfg_limit + 2;
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom_range(1)));
        1: wait_drained();
        default: begin
          old_len = $urandom_range(1) ? 0 : $urandom_range(span);
          run_measurement(old_len, $urandom_range(span), $urandom_range(span),
                          $urandom_range(4) == 0);
        end
      endcase
    end
  endtask

  // Receiver stalls at the configured rate
  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    echo_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("trigger_level", 17'(out_trigger_level), 17'(want.trigger));
        check_field("busy_res", 17'(out_busy_res), 17'(want.busy));
        check_field("done_res", 17'(out_done_res), 17'(want.done));
        check_field("status", 17'(out_status), 17'(want.status));
        check_field("pulse_width", 17'(out_pulse_width), 17'(want.width));
        check_field("distance_centi", 17'(out_distance_centi), 17'(want.distance));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_request = 1'b0;
    in_echo_level = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ticks_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    rng_phase = RANGE_IDLE;
    rng_count = '0;
    cfg_limit = TIMEOUT_RST;
    cfg_pol = POLARITY_RST;
    cfg_lo = TRIG_LOW_RST;
    cfg_hi = TRIG_HIGH_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_setup();
    test_active_low_echo();
    test_trigger_extremes();
    test_phase_timeouts();
    test_long_pulse();
    test_random_traffic(0, 0, 60);
    test_random_traffic(77, 0, 60);
    test_random_traffic(0, 77, 60);
    test_random_traffic(33, 33, 60);

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
